FILE: hdl/checksum_frame_receiver_top_macros.svh
// Assertion macros shared by the checksum frame receiver RTL.
`ifndef CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH
`define CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define CFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define CFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cfr_pkg.sv
// Types, constants and slot lookup for the checksum frame receiver.
package cfr_pkg;

  localparam int CODE_REGS    = 4;
  localparam int MAX_COMMANDS = 4;
  localparam int SLOT_LIMIT   = (MAX_COMMANDS < CODE_REGS) ? MAX_COMMANDS : CODE_REGS;

  localparam logic [7:0] SYNC_BYTE = 8'hE7;

  // Configuration register indexes
  localparam logic [2:0] CFG_COMMAND_COUNT  = 3'd0;
  localparam logic [2:0] CFG_COMMAND_CODE_0 = 3'd1;
  localparam logic [2:0] CFG_COMMAND_CODE_1 = 3'd2;
  localparam logic [2:0] CFG_COMMAND_CODE_2 = 3'd3;
  localparam logic [2:0] CFG_COMMAND_CODE_3 = 3'd4;

  typedef enum logic [5:0] {
    MODE_HUNT = 6'b000001,
    MODE_CMD  = 6'b000010,
    MODE_LEN  = 6'b000100,
    MODE_HCHK = 6'b001000,
    MODE_DATA = 6'b010000,
    MODE_DCHK = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [2:0]                command_count;
    logic [CODE_REGS-1:0][7:0] command_code;
  } cfg_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_cmd;
    logic [7:0] frame_length;
    logic       data_ok;
    logic       handler_found;
    logic [1:0] handler_slot;
  } result_t;

  typedef struct packed {
    logic       found;
    logic [1:0] slot;
  } match_t;

  // First slot below the active count whose code equals cmd
  function automatic match_t find_slot(cfg_t cfg, logic [7:0] cmd);
    match_t     m;
    logic [2:0] lim;
    lim = (cfg.command_count > 3'(SLOT_LIMIT)) ? 3'(SLOT_LIMIT) : cfg.command_count;
    m   = '0;
    for (int k = CODE_REGS - 1; k >= 0; k--) begin
      if ((3'(k) < lim) && (cfg.command_code[k] == cmd)) begin
        m.found = 1'b1;
        m.slot  = 2'(k);
      end
    end
    return m;
  endfunction

endpackage

FILE: hdl/cfr_byte_if.sv
// Received-byte channel: valid/ready with one rx_byte per beat.
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/cfr_result_if.sv
// Result channel: valid/ready with one payload or end-of-frame result per beat.
interface cfr_result_if;
  logic       valid;
  logic       ready;
  logic       frame_end;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_cmd;
  logic [7:0] frame_length;
  logic       data_ok;
  logic       handler_found;
  logic [1:0] handler_slot;

  modport source (output valid, output frame_end, output payload_byte,
                  output payload_index, output frame_cmd, output frame_length,
                  output data_ok, output handler_found, output handler_slot,
                  input ready);
  modport sink   (input valid, input frame_end, input payload_byte,
                  input payload_index, input frame_cmd, input frame_length,
                  input data_ok, input handler_found, input handler_slot,
                  output ready);
endinterface

FILE: hdl/cfr_cfg_regs.sv
// Command count and command code registers behind the write port.
module cfr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output cfr_pkg::cfg_t cfg
);
  import cfr_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COMMAND_COUNT:  cfg_nxt.command_count   = cfg_data[2:0];
        CFG_COMMAND_CODE_0: cfg_nxt.command_code[0] = cfg_data;
        CFG_COMMAND_CODE_1: cfg_nxt.command_code[1] = cfg_data;
        CFG_COMMAND_CODE_2: cfg_nxt.command_code[2] = cfg_data;
        CFG_COMMAND_CODE_3: cfg_nxt.command_code[3] = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/cfr_parser.sv
// Input byte register and frame state machine; emits one result per payload or data checksum byte.
module cfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  cfr_byte_if.sink        in_ch,
  input  cfr_pkg::cfg_t   cfg,
  input  logic            space,
  output logic            push,
  output cfr_pkg::result_t push_data
);
  import cfr_pkg::*;
  `include "checksum_frame_receiver_top_macros.svh"

  // Input stage
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r, in_byte_nxt;

  // Frame state
  mode_t      mode_r, mode_nxt;
  logic [7:0] cur_cmd_r, cur_cmd_nxt;
  logic [7:0] cur_length_r, cur_length_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] data_sum_r, data_sum_nxt;

  logic       produce;
  logic       adv;
  logic       in_ready;
  logic [7:0] hdr_sum;
  logic [7:0] cnt_inc;
  logic       data_ok;
  match_t     match;
  result_t    res;

  // Stage advances unless it holds a result with nowhere to go
  assign produce  = (mode_r == MODE_DATA) || (mode_r == MODE_DCHK);
  assign adv      = in_vld_r && (!produce || space);
  assign in_ready = !in_vld_r || adv;
  assign in_ch.ready = in_ready;

  assign hdr_sum = SYNC_BYTE + cur_cmd_r + cur_length_r;
  assign cnt_inc = byte_count_r + 8'd1;
  assign data_ok = (in_byte_r == ~data_sum_r);
  assign match   = find_slot(cfg, cur_cmd_r);

  // Load the input register on an accepted beat
  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_byte_nxt = in_byte_r;
    if (in_ready) begin
      in_vld_nxt = in_ch.valid;
      if (in_ch.valid) begin
        in_byte_nxt = in_ch.rx_byte;
      end
    end
  end

  // Frame state update and result build
  always_comb begin
    mode_nxt       = mode_r;
    cur_cmd_nxt    = cur_cmd_r;
    cur_length_nxt = cur_length_r;
    byte_count_nxt = byte_count_r;
    data_sum_nxt   = data_sum_r;
    res            = '0;
    res.frame_cmd    = cur_cmd_r;
    res.frame_length = cur_length_r;
    if (adv) begin
      case (mode_r)
        MODE_HUNT: begin
          if (in_byte_r == SYNC_BYTE) begin
            mode_nxt = MODE_CMD;
          end
        end
        MODE_CMD: begin
          cur_cmd_nxt = in_byte_r;
          mode_nxt    = MODE_LEN;
        end
        MODE_LEN: begin
          cur_length_nxt = in_byte_r;
          mode_nxt       = MODE_HCHK;
        end
        MODE_HCHK: begin
          byte_count_nxt = '0;
          data_sum_nxt   = '0;
          if (in_byte_r == ~hdr_sum) begin
            mode_nxt = (cur_length_r == 8'd0) ? MODE_DCHK : MODE_DATA;
          end else begin
            mode_nxt = MODE_HUNT;
          end
        end
        MODE_DATA: begin
          res.payload_byte  = in_byte_r;
          res.payload_index = byte_count_r;
          data_sum_nxt      = data_sum_r + in_byte_r;
          byte_count_nxt    = cnt_inc;
          if (cnt_inc == cur_length_r) begin
            mode_nxt = MODE_DCHK;
          end
        end
        MODE_DCHK: begin
          res.frame_end     = 1'b1;
          res.data_ok       = data_ok;
          res.handler_found = data_ok && match.found;
          res.handler_slot  = (data_ok && match.found) ? match.slot : 2'd0;
          mode_nxt          = MODE_HUNT;
          byte_count_nxt    = '0;
          data_sum_nxt      = '0;
        end
        default: mode_nxt = MODE_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      mode_r       <= MODE_HUNT;
      cur_cmd_r    <= '0;
      cur_length_r <= '0;
      byte_count_r <= '0;
      data_sum_r   <= '0;
    end else begin
      in_vld_r     <= in_vld_nxt;
      mode_r       <= mode_nxt;
      cur_cmd_r    <= cur_cmd_nxt;
      cur_length_r <= cur_length_nxt;
      byte_count_r <= byte_count_nxt;
      data_sum_r   <= data_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  assign push      = adv && produce;
  assign push_data = res;

  // Checks
  `CFR_ASSERT_IMP(a_push_has_room, push, space, "result pushed into a full output buffer")
  `CFR_ASSERT_NXT(a_end_to_hunt, push && res.frame_end, mode_r == MODE_HUNT, "no hunt after end result")
  `CFR_ASSERT_IMP(a_count_in_range, mode_r == MODE_DATA, byte_count_r < cur_length_r, "payload count overran length")

endmodule

FILE: hdl/cfr_out_fifo.sv
// Two-entry result buffer between the parser and the result channel.
module cfr_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfr_pkg::result_t push_data,
  output logic             space,
  cfr_result_if.source     out_ch
);
  import cfr_pkg::*;

  localparam int DEPTH = 2;

  result_t    mem_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;
  result_t    head;

  assign space = (count_r != 2'(DEPTH));
  assign pop   = out_ch.valid && out_ch.ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Head entry onto the channel
  assign head                 = mem_r[rd_ptr_r];
  assign out_ch.valid         = (count_r != 2'd0);
  assign out_ch.frame_end     = head.frame_end;
  assign out_ch.payload_byte  = head.payload_byte;
  assign out_ch.payload_index = head.payload_index;
  assign out_ch.frame_cmd     = head.frame_cmd;
  assign out_ch.frame_length  = head.frame_length;
  assign out_ch.data_ok       = head.data_ok;
  assign out_ch.handler_found = head.handler_found;
  assign out_ch.handler_slot  = head.handler_slot;

endmodule

FILE: hdl/checksum_frame_receiver_top.sv
// Top level of the checksum frame receiver: config registers, parser and result buffer.
//
//   channel  dir  handshake        beat contents
//   in_ch    in   valid/ready      rx_byte
//   out_ch   out  valid/ready      frame_end, payload_byte, payload_index, frame_cmd,
//                                  frame_length, data_ok, handler_found, handler_slot
//   cfg_*    in   cfg_we strobe    cfg_index, cfg_data
//
// One byte per cycle sustained while out_ch keeps up. A byte is held in the input
// register, and its result is then written into the two-entry output buffer.
// The frame state machine updates once per byte, which sets that rate.
// rst_n is synchronous, active low; it returns the parser to hunting and clears config.
// When out_ch stalls, the buffer fills and in_ch.ready drops only for bytes that
// produce a result; header bytes keep flowing.
module checksum_frame_receiver_top (
  input  logic          clk,
  input  logic          rst_n,
  cfr_byte_if.sink      in_ch,
  cfr_result_if.source  out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data
);
  import cfr_pkg::*;

  cfg_t    cfg;
  logic    space;
  logic    push;
  result_t push_data;

  cfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .space     (space),
    .push      (push),
    .push_data (push_data)
  );

  cfr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_ch    (out_ch)
  );

endmodule
